@@ rtl/core/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg
// shared constants and types for the piecewise linear interpolator
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int MaxPoints = 1024;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;
  localparam int DataW     = 32;

  localparam logic [1:0] CMD_LOAD_X = 2'd0;
  localparam logic [1:0] CMD_LOAD_V = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_LOW    = 2'd1;
  localparam logic [1:0] ST_HIGH   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic            wr_x;
    logic            wr_v;
    logic            cap_q;     // latch the query position
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            cap_x0;    // capture x[addr] into first-knot reg
    logic            cap_xl;    // capture x[addr] into last-knot reg
    logic            cap_xa;    // capture x[addr] as lower interp knot
    logic            cap_xb;    // capture x[addr] as upper interp knot
    logic            cap_va;
    logic            cap_vb;
    logic            cmp_mid;   // compare read x against query
    logic            mul_go;
    logic            div_go;
    logic            div_step;
    logic            fin;       // form final result
  } pli_cmd_t;

  typedef struct packed {
    logic x_lt_q;               // last read x is below the query
    logic q_le_x0;
    logic q_ge_xl;
  } pli_sts_t;

endpackage

@@ rtl/core/pli_datapath.sv @@
// ----------------------------------------------------------------------------
// pli_datapath
// knot memories, compare, product, restoring divider and result forming
// ----------------------------------------------------------------------------
module pli_datapath import pli_pkg::*; (
  input  logic                    clk,
  input  pli_cmd_t                cmd,
  output pli_sts_t                sts,
  input  logic [IdxW-1:0]         wr_addr,
  input  logic signed [DataW-1:0] wr_data,
  input  logic signed [DataW-1:0] query,
  input  logic [1:0]              res_status,
  output logic signed [DataW-1:0] res_value
);

  logic signed [DataW-1:0] xmem [MaxPoints];
  logic signed [DataW-1:0] vmem [MaxPoints];
  logic signed [DataW-1:0] xrd_r, vrd_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_x) xmem[wr_addr] <= wr_data;
    if (cmd.wr_v) vmem[wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      xrd_r <= xmem[cmd.rd_addr];
      vrd_r <= vmem[cmd.rd_addr];
    end
  end

  logic signed [DataW-1:0] query_r;
  logic signed [DataW-1:0] x0_r, xl_r, xa_r, xb_r, va_r, vb_r, vl_r, v0_r;
  logic x_lt_q_r;
  logic [DataW:0]     mdy_r, mdq_r, mdx_r;
  logic               neg_r;
  logic [2*DataW+1:0] prod;

  logic signed [DataW:0] dy, dq, dx;
  assign dy = {vb_r[DataW-1], vb_r} - {va_r[DataW-1], va_r};
  assign dq = {query_r[DataW-1], query_r} - {xa_r[DataW-1], xa_r};
  assign dx = {xb_r[DataW-1], xb_r} - {xa_r[DataW-1], xa_r};

  assign prod = {1'b0, mdy_r} * {1'b0, mdq_r};

  always_ff @(posedge clk) begin
    if (cmd.cap_q) query_r <= query;
    if (cmd.cap_x0) begin x0_r <= xrd_r; v0_r <= vrd_r; end
    if (cmd.cap_xl) begin xl_r <= xrd_r; vl_r <= vrd_r; end
    if (cmd.cap_xa) xa_r <= xrd_r;
    if (cmd.cap_xb) xb_r <= xrd_r;
    if (cmd.cap_va) va_r <= vrd_r;
    if (cmd.cap_vb) vb_r <= vrd_r;
    if (cmd.cmp_mid) x_lt_q_r <= (xrd_r < query_r);
    if (cmd.mul_go) begin
      mdy_r <= dy[DataW] ? (DataW+1)'(0) - dy : dy;
      mdq_r <= dq[DataW] ? (DataW+1)'(0) - dq : dq;
      mdx_r <= dx[DataW] ? (DataW+1)'(0) - dx : dx;
      neg_r <= dy[DataW] ^ dq[DataW] ^ dx[DataW];
    end
  end

  // restoring divider, one quotient bit per step, dividend shifted in from the top
  logic [2*DataW+1:0] num_r;
  logic [2*DataW+1:0] rm_r;
  logic [2*DataW+1:0] quo_r;
  logic [2*DataW+2:0] rm_sh, rm_sub;
  assign rm_sh  = {rm_r, num_r[2*DataW+1]};
  assign rm_sub = rm_sh - {{(DataW+2){1'b0}}, mdx_r};

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      num_r <= prod;
      rm_r  <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[2*DataW:0], 1'b0};
      if (!rm_sub[2*DataW+2]) begin
        rm_r  <= rm_sub[2*DataW+1:0];
        quo_r <= {quo_r[2*DataW:0], 1'b1};
      end else begin
        rm_r  <= rm_sh[2*DataW+1:0];
        quo_r <= {quo_r[2*DataW:0], 1'b0};
      end
    end
  end

  logic [2*DataW+1:0]  qclip;
  logic signed [DataW+9:0] step, sum;
  localparam logic [2*DataW+1:0] QMax = (2*DataW+2)'(64'hFF_FFFF_FFFF);
  assign qclip = (quo_r > QMax) ? QMax : quo_r;
  assign step  = neg_r ? -$signed({2'b0, qclip[DataW+7:0]})
                       :  $signed({2'b0, qclip[DataW+7:0]});
  assign sum   = $signed({{10{va_r[DataW-1]}}, va_r}) + step;

  logic signed [DataW-1:0] sat;
  always_comb begin
    if (sum > $signed({{10{1'b0}}, {1'b0, {(DataW-1){1'b1}}}}))
      sat = {1'b0, {(DataW-1){1'b1}}};
    else if (sum < $signed({{10{1'b1}}, {1'b1, {(DataW-1){1'b0}}}}))
      sat = {1'b1, {(DataW-1){1'b0}}};
    else
      sat = sum[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      unique case (res_status)
        ST_LOW:  res_value <= v0_r;
        ST_HIGH: res_value <= vl_r;
        default: res_value <= sat;
      endcase
    end
  end

  assign sts.x_lt_q  = x_lt_q_r;
  assign sts.q_le_x0 = (query_r <= x0_r);
  assign sts.q_ge_xl = (query_r >= xl_r);

endmodule

@@ rtl/core/pli_ctrl.sv @@
// ----------------------------------------------------------------------------
// pli_ctrl
// sequencer for loads, binary search and the divide loop
// ----------------------------------------------------------------------------
module pli_ctrl import pli_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [1:0]      in_cmd,
  input  logic [CntW-1:0] npts,
  input  logic            out_busy,
  input  pli_sts_t        sts,
  output pli_cmd_t        cmd,
  output logic            busy,
  output logic [1:0]      res_status,
  output logic [CntW-1:0] res_index,
  output logic            res_done
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_CAP0, S_CAPL, S_SRD, S_SCMP, S_SUPD,
    S_RDA, S_RDB, S_CAPB, S_MUL, S_DIVL, S_DIV, S_FIN
  } state_t;

  state_t          state_r;
  logic [CntW-1:0] lo_r, hi_r, k_r;
  logic [6:0]      cnt_r;
  logic [1:0]      st_r;
  logic            done_r;
  logic [CntW-1:0] mid;
  assign mid = CntW'((lo_r + hi_r) >> 1);

  always_comb begin
    cmd = '0;
    cmd.wr_x  = in_fire && in_cmd == CMD_LOAD_X;
    cmd.wr_v  = in_fire && in_cmd == CMD_LOAD_V;
    cmd.cap_q = in_fire && in_cmd == CMD_QUERY;
    unique case (state_r)
      S_RD0:  begin cmd.rd_en = 1'b1; cmd.rd_addr = '0; end
      S_CAP0: begin
        cmd.cap_x0 = 1'b1; cmd.rd_en = 1'b1;
        cmd.rd_addr = IdxW'(npts - CntW'(1));
      end
      S_CAPL: cmd.cap_xl = 1'b1;
      S_SRD:  begin cmd.rd_en = 1'b1; cmd.rd_addr = mid[IdxW-1:0]; end
      S_SCMP: cmd.cmp_mid = 1'b1;
      S_RDA:  begin cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(k_r - CntW'(1)); end
      S_RDB:  begin
        cmd.cap_xa = 1'b1; cmd.cap_va = 1'b1;
        cmd.rd_en = 1'b1; cmd.rd_addr = k_r[IdxW-1:0];
      end
      S_CAPB: begin cmd.cap_xb = 1'b1; cmd.cap_vb = 1'b1; end
      S_MUL:  cmd.mul_go = 1'b1;
      S_DIVL: cmd.div_go = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_FIN:  cmd.fin = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_fire && in_cmd == CMD_QUERY) begin
          state_r <= S_RD0;
          lo_r <= '0;
          hi_r <= npts;
        end
        S_RD0:  state_r <= S_CAP0;
        S_CAP0: state_r <= S_CAPL;
        S_CAPL: state_r <= S_SRD;
        S_SRD:  state_r <= (lo_r < hi_r) ? S_SCMP : S_SUPD;
        S_SCMP: state_r <= S_SUPD;
        S_SUPD: begin
          if (lo_r < hi_r) begin
            if (sts.x_lt_q) lo_r <= mid + CntW'(1);
            else            hi_r <= mid;
            state_r <= S_SRD;
          end else begin
            k_r <= (lo_r < CntW'(1)) ? CntW'(1)
                 : (lo_r > npts - CntW'(1)) ? npts - CntW'(1) : lo_r;
            if (sts.q_le_x0) begin st_r <= ST_LOW; state_r <= S_FIN; end
            else if (sts.q_ge_xl) begin st_r <= ST_HIGH; state_r <= S_FIN; end
            else begin st_r <= ST_INTERP; state_r <= S_RDA; end
          end
        end
        S_RDA:  state_r <= S_RDB;
        S_RDB:  state_r <= S_CAPB;
        S_CAPB: state_r <= S_MUL;
        S_MUL:  state_r <= S_DIVL;
        S_DIVL: begin cnt_r <= 7'd66; state_r <= S_DIV; end
        S_DIV:  begin
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) state_r <= S_FIN;
        end
        // hold here until the output register is free
        S_FIN:  if (!out_busy) begin done_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = state_r != S_IDLE;
  assign res_status = st_r;
  assign res_index  = lo_r;
  assign res_done   = done_r;

endmodule

@@ rtl/core/piecewise_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// knot table loader and lower-bound search linear interpolator
// ----------------------------------------------------------------------------
// channel | dir | signals              | content
// in      | in  | tvalid tready tdata  | command, entry_index, load_value, query_x
// out     | out | tvalid tready tdata  | interp_value, found_index, status
// cfg     | in  | wen wdata            | num_points
//
// a query blocks the input while it reads the first and last knots and runs s search
// steps (at most floor(log2(n))+1), and when interpolated also while it does the lower
// and upper knot reads, one multiply, divider load and 66 divide steps
// one query is in work at a time; in_tready drops while it runs
// a result waiting in the output register does not block the input; a finished
// query holds in its last state until the register is free
// reset clears control and sets num_points to 1024; knot tables are not cleared
module piecewise_linear_interpolator import pli_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] command, [11:2] entry_index, [43:12] load_value, [75:44] query_x
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] interp_value, [42:32] found_index, [44:43] status
  output logic [47:0]  out_tdata,
  input  logic         cfg_wen,
  input  logic [10:0]  cfg_wdata
);

  logic [CntW-1:0] npts_r, npts;
  logic            in_fire, busy, res_done, ovalid_r;
  pli_cmd_t        cmd;
  pli_sts_t        sts;
  logic [1:0]      res_status;
  logic [CntW-1:0] res_index;
  logic signed [DataW-1:0] res_value;
  logic [47:0]     odata_r;

  // clamp knot count to 1..MaxPoints
  assign npts = (npts_r == '0) ? CntW'(1)
              : (npts_r > CntW'(MaxPoints)) ? CntW'(MaxPoints) : npts_r;

  assign in_tready = !busy && !res_done;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npts_r   <= CntW'(MaxPoints);
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_wen) npts_r <= cfg_wdata;
      if (res_done) begin
        ovalid_r <= 1'b1;
        odata_r  <= {3'b0, res_status, res_index, res_value};
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  pli_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_cmd(in_tdata[1:0]), .npts, .out_busy(ovalid_r), .sts, .cmd, .busy,
    .res_status, .res_index, .res_done
  );

  pli_datapath u_dp (
    .clk, .cmd, .sts,
    .wr_addr(in_tdata[11:2]),
    .wr_data(in_tdata[43:12]),
    .query(in_tdata[75:44]),
    .res_status, .res_value
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule
